/* rtl/dtzm_pkg.sv */
// ----------------------------------------------------------------------------
// dtzm_pkg
// Shared types, constants and helper functions for the dual temperature
// zone monitor.
// ----------------------------------------------------------------------------
package dtzm_pkg;

   localparam int TEMP_W   = 15;
   localparam int REPORT_W = 14;
   localparam int ZONE_W   = 3;
   localparam int QUIET_W  = 12;
   localparam int HOLD_W   = 6;
   localparam int UNIT_W   = 8;
   localparam int MAGIC_W  = 32;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 3;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [QUIET_W-1:0] STALE_MS    = QUIET_W'(3000);
   localparam logic [QUIET_W-1:0] QUIET_MAX   = QUIET_W'(4095);
   localparam logic [HOLD_W-1:0]  HOLD_MIN_MS = HOLD_W'(30);
   localparam logic [HOLD_W-1:0]  HOLD_MAX    = HOLD_W'(63);

   localparam logic signed [TEMP_W-1:0] MIN_NONE   = TEMP_W'(16383);
   localparam logic signed [TEMP_W-1:0] MAX_START  = '0;
   localparam logic signed [TEMP_W-1:0] REPORT_MAX = TEMP_W'(11000);

   localparam logic signed [TEMP_W-1:0] PAD_COLD_RESET      = TEMP_W'(600);
   localparam logic signed [TEMP_W-1:0] PAD_AMBER_RESET     = TEMP_W'(3000);
   localparam logic signed [TEMP_W-1:0] PAD_RED_RESET       = TEMP_W'(4500);
   localparam logic signed [TEMP_W-1:0] CALIPER_COLD_RESET  = TEMP_W'(500);
   localparam logic signed [TEMP_W-1:0] CALIPER_AMBER_RESET = TEMP_W'(1500);
   localparam logic signed [TEMP_W-1:0] CALIPER_RED_RESET   = TEMP_W'(2200);

   typedef enum logic [ZONE_W-1:0] {
      ZONE_STALE = 3'd0,
      ZONE_COLD  = 3'd1,
      ZONE_GREEN = 3'd2,
      ZONE_AMBER = 3'd3,
      ZONE_RED   = 3'd4,
      ZONE_FAULT = 3'd5
   } zone_type;

   typedef enum logic {
      OP_PACKET = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PAD_COLD      = 3'd0,
      CSR_PAD_AMBER     = 3'd1,
      CSR_PAD_RED       = 3'd2,
      CSR_CALIPER_COLD  = 3'd3,
      CSR_CALIPER_AMBER = 3'd4,
      CSR_CALIPER_RED   = 3'd5,
      CSR_PAIRED_UNIT   = 3'd6,
      CSR_EXPECTED_MAGIC = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] cold;
      logic signed [TEMP_W-1:0] amber;
      logic signed [TEMP_W-1:0] red;
   } limits_type;

   typedef struct packed {
      logic                     is_tick;
      logic                     pkt_ok;
      logic signed [TEMP_W-1:0] pad_temp;
      logic signed [TEMP_W-1:0] caliper_temp;
      logic                     pad_fault;
      logic                     caliper_fault;
      logic                     button_down;
   } cmd_type;

   typedef struct packed {
      zone_type                   pad_zone;
      zone_type                   caliper_zone;
      zone_type                   worst_zone;
      logic                       link_stale;
      logic signed [TEMP_W-1:0]   pad_min;
      logic signed [TEMP_W-1:0]   pad_max;
      logic signed [TEMP_W-1:0]   caliper_min;
      logic signed [TEMP_W-1:0]   caliper_max;
      logic [REPORT_W-1:0]        pad_report;
      logic [REPORT_W-1:0]        caliper_report;
   } result_type;

   function automatic zone_type zone_of(
      input logic signed [TEMP_W-1:0] t,
      input limits_type               lim,
      input logic                     fault,
      input logic                     stale
   );
      zone_type z;
      if (stale) begin
         z = ZONE_STALE;
      end else if (fault) begin
         z = ZONE_FAULT;
      end else if (t >= lim.red) begin
         z = ZONE_RED;
      end else if (t >= lim.amber) begin
         z = ZONE_AMBER;
      end else if (t < lim.cold) begin
         z = ZONE_COLD;
      end else begin
         z = ZONE_GREEN;
      end
      return z;
   endfunction

   function automatic logic [REPORT_W-1:0] report_of(
      input logic signed [TEMP_W-1:0] t
   );
      logic [REPORT_W-1:0] r;
      if (t < 0) begin
         r = '0;
      end else if (t > REPORT_MAX) begin
         r = REPORT_MAX[REPORT_W-1:0];
      end else begin
         r = t[REPORT_W-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/dtzm_fifo.sv */
// ----------------------------------------------------------------------------
// dtzm_fifo
// Small show-ahead queue used between the front, the back and the result
// port.
// ----------------------------------------------------------------------------
module dtzm_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/dtzm_front.sv */
// ----------------------------------------------------------------------------
// dtzm_front
// Request classifier: checks packet framing, magic word and unit id and
// forms a command for the back end.
// ----------------------------------------------------------------------------
module dtzm_front (
   input  logic                                  req_op,
   input  logic                                  req_frame_len_ok,
   input  logic [dtzm_pkg::MAGIC_W-1:0]          req_magic_word,
   input  logic [dtzm_pkg::UNIT_W-1:0]           req_unit_id,
   input  logic signed [dtzm_pkg::TEMP_W-1:0]    req_pad_temp,
   input  logic signed [dtzm_pkg::TEMP_W-1:0]    req_caliper_temp,
   input  logic                                  req_pad_fault,
   input  logic                                  req_caliper_fault,
   input  logic                                  req_button_down,
   input  logic [dtzm_pkg::MAGIC_W-1:0]          expected_magic,
   input  logic [dtzm_pkg::UNIT_W-1:0]           paired_unit,
   output dtzm_pkg::cmd_type                     cmd
);
   import dtzm_pkg::*;

   logic is_tick;

   assign is_tick = (op_type'(req_op) == OP_TICK);

   always_comb begin
      cmd.is_tick       = is_tick;
      cmd.pkt_ok        = !is_tick && req_frame_len_ok
                          && (req_magic_word == expected_magic)
                          && (req_unit_id == paired_unit);
      cmd.pad_temp      = req_pad_temp;
      cmd.caliper_temp  = req_caliper_temp;
      cmd.pad_fault     = req_pad_fault;
      cmd.caliper_fault = req_caliper_fault;
      cmd.button_down   = req_button_down;
   end

endmodule

/* rtl/dtzm_back.sv */
// ----------------------------------------------------------------------------
// dtzm_back
// Executes commands: updates readings, link timer, session extremes and
// button hold, then forms the zone report for each request.
// ----------------------------------------------------------------------------
module dtzm_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  dtzm_pkg::cmd_type      cmd,
   output logic                   cmd_pop,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output dtzm_pkg::result_type   rsp,
   input  dtzm_pkg::limits_type   pad_limits,
   input  dtzm_pkg::limits_type   caliper_limits
);
   import dtzm_pkg::*;

   logic signed [TEMP_W-1:0] latest_pad_ff, latest_pad_in;
   logic signed [TEMP_W-1:0] latest_caliper_ff, latest_caliper_in;
   logic                     pad_fault_ff, pad_fault_in;
   logic                     caliper_fault_ff, caliper_fault_in;
   logic                     ever_ff, ever_in;
   logic [QUIET_W-1:0]       quiet_ff, quiet_in;
   logic signed [TEMP_W-1:0] pad_min_ff, pad_min_in;
   logic signed [TEMP_W-1:0] pad_max_ff, pad_max_in;
   logic signed [TEMP_W-1:0] caliper_min_ff, caliper_min_in;
   logic signed [TEMP_W-1:0] caliper_max_ff, caliper_max_in;
   logic                     button_ff, button_in;
   logic [HOLD_W-1:0]        hold_ff, hold_in;
   logic                     fire;
   logic                     stale;
   zone_type                 pad_zone, caliper_zone;

   assign fire     = cmd_valid && !rsp_full;
   assign cmd_pop  = fire;
   assign rsp_push = fire;

   always_comb begin
      latest_pad_in     = latest_pad_ff;
      latest_caliper_in = latest_caliper_ff;
      pad_fault_in      = pad_fault_ff;
      caliper_fault_in  = caliper_fault_ff;
      ever_in           = ever_ff;
      quiet_in          = quiet_ff;
      pad_min_in        = pad_min_ff;
      pad_max_in        = pad_max_ff;
      caliper_min_in    = caliper_min_ff;
      caliper_max_in    = caliper_max_ff;
      button_in         = button_ff;
      hold_in           = hold_ff;

      if (cmd.is_tick) begin
         if (quiet_ff < QUIET_MAX) begin
            quiet_in = quiet_ff + 1'b1;
         end
         if (cmd.button_down && !button_ff) begin
            hold_in = HOLD_W'(1);
         end else if (cmd.button_down) begin
            if (hold_ff < HOLD_MAX) begin
               hold_in = hold_ff + 1'b1;
            end
         end else if (button_ff && (hold_ff > HOLD_MIN_MS)) begin
            pad_min_in     = MIN_NONE;
            pad_max_in     = MAX_START;
            caliper_min_in = MIN_NONE;
            caliper_max_in = MAX_START;
         end
         button_in = cmd.button_down;
      end else if (cmd.pkt_ok) begin
         latest_pad_in     = cmd.pad_temp;
         latest_caliper_in = cmd.caliper_temp;
         pad_fault_in      = cmd.pad_fault;
         caliper_fault_in  = cmd.caliper_fault;
         ever_in           = 1'b1;
         quiet_in          = '0;
         if (!cmd.pad_fault) begin
            if (cmd.pad_temp > pad_max_ff) begin
               pad_max_in = cmd.pad_temp;
            end
            if (cmd.pad_temp < pad_min_ff) begin
               pad_min_in = cmd.pad_temp;
            end
         end
         if (!cmd.caliper_fault) begin
            if (cmd.caliper_temp > caliper_max_ff) begin
               caliper_max_in = cmd.caliper_temp;
            end
            if (cmd.caliper_temp < caliper_min_ff) begin
               caliper_min_in = cmd.caliper_temp;
            end
         end
      end
   end

   assign stale        = !ever_in || (quiet_in > STALE_MS);
   assign pad_zone     = zone_of(latest_pad_in, pad_limits, pad_fault_in, stale);
   assign caliper_zone = zone_of(latest_caliper_in, caliper_limits, caliper_fault_in, stale);

   always_comb begin
      rsp.pad_zone       = pad_zone;
      rsp.caliper_zone   = caliper_zone;
      rsp.worst_zone     = (pad_zone > caliper_zone) ? pad_zone : caliper_zone;
      rsp.link_stale     = stale;
      rsp.pad_min        = pad_min_in;
      rsp.pad_max        = pad_max_in;
      rsp.caliper_min    = caliper_min_in;
      rsp.caliper_max    = caliper_max_in;
      rsp.pad_report     = report_of(latest_pad_in);
      rsp.caliper_report = report_of(latest_caliper_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latest_pad_ff     <= '0;
         latest_caliper_ff <= '0;
         pad_fault_ff      <= 1'b0;
         caliper_fault_ff  <= 1'b0;
         ever_ff           <= 1'b0;
         quiet_ff          <= '0;
         pad_min_ff        <= MIN_NONE;
         pad_max_ff        <= MAX_START;
         caliper_min_ff    <= MIN_NONE;
         caliper_max_ff    <= MAX_START;
         button_ff         <= 1'b0;
         hold_ff           <= '0;
      end else if (fire) begin
         latest_pad_ff     <= latest_pad_in;
         latest_caliper_ff <= latest_caliper_in;
         pad_fault_ff      <= pad_fault_in;
         caliper_fault_ff  <= caliper_fault_in;
         ever_ff           <= ever_in;
         quiet_ff          <= quiet_in;
         pad_min_ff        <= pad_min_in;
         pad_max_ff        <= pad_max_in;
         caliper_min_ff    <= caliper_min_in;
         caliper_max_ff    <= caliper_max_in;
         button_ff         <= button_in;
         hold_ff           <= hold_in;
      end
   end

endmodule

/* rtl/dual_temp_zone_monitor.sv */
// ----------------------------------------------------------------------------
// dual_temp_zone_monitor
// Pad and caliper temperature monitor with link timeout, session extremes
// and per-channel zone report.
//
//   channel   ports                         direction   handshake
//   request   req_*                         in          push / full
//   response  rsp_*                         out         pop / empty
//   control   csr_we, csr_index, csr_data   in          write only
//
// One request per cycle sustained while the response queue is not full; a
// request is registered in the command queue, then the back end updates its
// state and writes the response into the response queue, from which it can
// be popped. Reset clears all state and both queues. A stalled response side
// fills the response queue, then the command queue, then raises full.
// ----------------------------------------------------------------------------
module dual_temp_zone_monitor #(
   parameter int QUEUE_DEPTH = dtzm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  logic                                   req_op,
   input  logic                                   req_frame_len_ok,
   input  logic [dtzm_pkg::MAGIC_W-1:0]           req_magic_word,
   input  logic [dtzm_pkg::UNIT_W-1:0]            req_unit_id,
   input  logic signed [dtzm_pkg::TEMP_W-1:0]     req_pad_temp,
   input  logic signed [dtzm_pkg::TEMP_W-1:0]     req_caliper_temp,
   input  logic                                   req_pad_fault,
   input  logic                                   req_caliper_fault,
   input  logic                                   req_button_down,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output logic [dtzm_pkg::ZONE_W-1:0]            rsp_pad_zone,
   output logic [dtzm_pkg::ZONE_W-1:0]            rsp_caliper_zone,
   output logic [dtzm_pkg::ZONE_W-1:0]            rsp_worst_zone,
   output logic                                   rsp_link_stale,
   output logic signed [dtzm_pkg::TEMP_W-1:0]     rsp_pad_min,
   output logic signed [dtzm_pkg::TEMP_W-1:0]     rsp_pad_max,
   output logic signed [dtzm_pkg::TEMP_W-1:0]     rsp_caliper_min,
   output logic signed [dtzm_pkg::TEMP_W-1:0]     rsp_caliper_max,
   output logic [dtzm_pkg::REPORT_W-1:0]          rsp_pad_report,
   output logic [dtzm_pkg::REPORT_W-1:0]          rsp_caliper_report,
   input  logic                                   csr_we,
   input  logic [dtzm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [dtzm_pkg::CSR_W-1:0]             csr_data
);
   import dtzm_pkg::*;

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(result_type);

   limits_type         pad_limits_ff, caliper_limits_ff;
   logic [UNIT_W-1:0]  paired_unit_ff;
   logic [MAGIC_W-1:0] expected_magic_ff;

   cmd_type            front_cmd, back_cmd;
   logic [CMD_W-1:0]   cmd_q_data;
   logic               cmd_empty, cmd_pop;
   result_type         back_rsp, out_rsp;
   logic [RSP_W-1:0]   rsp_q_data;
   logic               rsp_full, rsp_push;

   always_ff @(posedge clock) begin
      if (reset) begin
         pad_limits_ff.cold      <= PAD_COLD_RESET;
         pad_limits_ff.amber     <= PAD_AMBER_RESET;
         pad_limits_ff.red       <= PAD_RED_RESET;
         caliper_limits_ff.cold  <= CALIPER_COLD_RESET;
         caliper_limits_ff.amber <= CALIPER_AMBER_RESET;
         caliper_limits_ff.red   <= CALIPER_RED_RESET;
         paired_unit_ff          <= '0;
         expected_magic_ff       <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PAD_COLD:       pad_limits_ff.cold      <= csr_data[TEMP_W-1:0];
            CSR_PAD_AMBER:      pad_limits_ff.amber     <= csr_data[TEMP_W-1:0];
            CSR_PAD_RED:        pad_limits_ff.red       <= csr_data[TEMP_W-1:0];
            CSR_CALIPER_COLD:   caliper_limits_ff.cold  <= csr_data[TEMP_W-1:0];
            CSR_CALIPER_AMBER:  caliper_limits_ff.amber <= csr_data[TEMP_W-1:0];
            CSR_CALIPER_RED:    caliper_limits_ff.red   <= csr_data[TEMP_W-1:0];
            CSR_PAIRED_UNIT:    paired_unit_ff          <= csr_data[UNIT_W-1:0];
            CSR_EXPECTED_MAGIC: expected_magic_ff       <= csr_data[MAGIC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   dtzm_front u_front (
      .req_op            (req_op),
      .req_frame_len_ok  (req_frame_len_ok),
      .req_magic_word    (req_magic_word),
      .req_unit_id       (req_unit_id),
      .req_pad_temp      (req_pad_temp),
      .req_caliper_temp  (req_caliper_temp),
      .req_pad_fault     (req_pad_fault),
      .req_caliper_fault (req_caliper_fault),
      .req_button_down   (req_button_down),
      .expected_magic    (expected_magic_ff),
      .paired_unit       (paired_unit_ff),
      .cmd               (front_cmd)
   );

   dtzm_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_q_data),
      .empty     (cmd_empty)
   );

   assign back_cmd = cmd_type'(cmd_q_data);

   dtzm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (!cmd_empty),
      .cmd            (back_cmd),
      .cmd_pop        (cmd_pop),
      .rsp_full       (rsp_full),
      .rsp_push       (rsp_push),
      .rsp            (back_rsp),
      .pad_limits     (pad_limits_ff),
      .caliper_limits (caliper_limits_ff)
   );

   dtzm_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_q_data),
      .empty     (rsp_empty)
   );

   assign out_rsp            = result_type'(rsp_q_data);
   assign rsp_pad_zone       = out_rsp.pad_zone;
   assign rsp_caliper_zone   = out_rsp.caliper_zone;
   assign rsp_worst_zone     = out_rsp.worst_zone;
   assign rsp_link_stale     = out_rsp.link_stale;
   assign rsp_pad_min        = out_rsp.pad_min;
   assign rsp_pad_max        = out_rsp.pad_max;
   assign rsp_caliper_min    = out_rsp.caliper_min;
   assign rsp_caliper_max    = out_rsp.caliper_max;
   assign rsp_pad_report     = out_rsp.pad_report;
   assign rsp_caliper_report = out_rsp.caliper_report;

   a_stale_zones: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_link_stale == (rsp_pad_zone == ZONE_STALE))
                     && (rsp_link_stale == (rsp_caliper_zone == ZONE_STALE)))
      else $error("link stale flag disagrees with zones");

   a_worst_zone: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_worst_zone >= rsp_pad_zone)
                     && (rsp_worst_zone >= rsp_caliper_zone)
                     && ((rsp_worst_zone == rsp_pad_zone)
                         || (rsp_worst_zone == rsp_caliper_zone)))
      else $error("worst zone is not the larger channel zone");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not cleared by reset");

   a_no_lost_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !rsp_full)
      else $error("command consumed while response queue full");

endmodule
